// ===== rtl/core/serial_line_editor_defines.svh =====
// Assertion macros shared by the line editor RTL.
`ifndef SERIAL_LINE_EDITOR_DEFINES_SVH
`define SERIAL_LINE_EDITOR_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define SLE_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SLE_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SLE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;

  localparam int unsigned CFG_W = 6;

  localparam logic [7:0] KEY_DEL   = 8'h7f;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_LF    = 8'h0a;
  localparam logic [7:0] KEY_CR    = 8'h0d;
  localparam logic [7:0] KEY_SPACE = 8'h20;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_BS,
    OP_EOL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/sle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sle_front
  import sle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic cmd_vld_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;

  assign in_stall = cmd_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = cmd_vld_r && !q_full;
  assign q_cmd    = cmd_r;

  // DEL folds into backspace; the echo carries the folded byte.
  always_comb begin
    cmd_nxt.ch = in_rx_byte;
    unique case (in_rx_byte)
      KEY_DEL, KEY_BS: begin
        cmd_nxt.op = OP_BS;
        cmd_nxt.ch = KEY_BS;
      end
      KEY_CR, KEY_LF: cmd_nxt.op = OP_EOL;
      default:        cmd_nxt.op = OP_CHAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        cmd_vld_r <= 1'b1;
        cmd_r     <= cmd_nxt;
      end else if (q_push) begin
        cmd_vld_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sle_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_line_editor_defines.svh"
module sle_queue
  import sle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r         <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  `SLE_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full), "push into full queue")
  `SLE_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty), "pop from empty queue")

endmodule
`default_nettype wire

// ===== rtl/core/sle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_line_editor_defines.svh"
module sle_back
  import sle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CFG_W-1:0] max_length,
  input  wire logic             q_empty,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_value,
  output logic                  out_last_of_run
);

  localparam int unsigned CW = $clog2(LINE_DEPTH);
  localparam logic [CFG_W-1:0] CAP_MAX = CFG_W'(LINE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPACE,
    S_BACK,
    S_FLUSH,
    S_END
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  idx_r;
  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic [7:0]     out_value_r;
  logic           out_last_r;
  logic [7:0]     rd_data_r;
  logic [7:0]     line_mem [LINE_DEPTH];

  logic           out_free;
  logic [CFG_W-1:0] cap_raw;
  logic [CFG_W-1:0] cap;
  logic           can_store;
  logic           wr_en;
  logic           flush_last;
  logic           flush_step;
  logic [CW-1:0]  rd_addr;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_empty && out_free;

  assign cap_raw   = (max_length == '0) ? '0 : max_length - 1'b1;
  assign cap       = (cap_raw > CAP_MAX) ? CAP_MAX : cap_raw;
  assign can_store = CFG_W'(count_r) < cap;
  assign wr_en     = q_pop && (q_cmd.op == OP_CHAR) && can_store;

  assign flush_last = (idx_r == count_r - 1'b1);
  assign flush_step = (state_r == S_FLUSH) && out_free && !flush_last;
  // Read one entry ahead so a line byte leaves every cycle that out_stall is low.
  assign rd_addr = (state_r != S_FLUSH) ? '0 : (flush_step ? idx_r + 1'b1 : idx_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[count_r] <= q_cmd.ch;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_value_r <= q_cmd.ch;
            out_last_r  <= 1'b1;
            idx_r       <= '0;
            unique case (q_cmd.op)
              OP_BS: begin
                if (count_r != '0) begin
                  count_r    <= count_r - 1'b1;
                  out_last_r <= 1'b0;
                  state_r    <= S_SPACE;
                end
              end
              OP_EOL: begin
                out_last_r <= 1'b0;
                state_r    <= (count_r == '0) ? S_END : S_FLUSH;
              end
              default: begin
                if (can_store) begin
                  count_r <= count_r + 1'b1;
                end
              end
            endcase
          end
        end
        S_SPACE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_value_r <= KEY_SPACE;
            out_last_r  <= 1'b0;
            state_r     <= S_BACK;
          end
        end
        S_BACK: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_value_r <= KEY_BS;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_LINE;
            out_value_r <= rd_data_r;
            out_last_r  <= 1'b0;
            if (flush_last) begin
              state_r <= S_END;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_END: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_END;
            out_value_r <= 8'(count_r);
            out_last_r  <= 1'b1;
            count_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_value       = out_value_r;
  assign out_last_of_run = out_last_r;

  `SLE_ASSERT_SAME(a_flush_has_data, clk, rst_n, state_r == S_FLUSH, count_r != '0, "flush with empty line")
  `SLE_ASSERT_NEXT(a_end_clears, clk, rst_n, (state_r == S_END) && out_free, count_r == '0, "line not cleared after end marker")
  `SLE_ASSERT_NEXT(a_pop_emits, clk, rst_n, q_pop, out_valid_r && (out_kind_r == KIND_ECHO), "pop without echo")

endmodule
`default_nettype wire

// ===== rtl/core/serial_line_editor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The echo passes the front-end command register, a queue slot and the back-end
//   output register. Throughput, out_stall low: plain bytes 1 item/cycle; held
//   line backspace gives BS, space, BS; CR/LF gives echo, held bytes, end
//   marker; the back end drives its single output register one result per cycle.
// Reset (sync, active low): line empty, max_length = 32, queue and output empty;
//   the line memory is not cleared.
module serial_line_editor
  import sle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_value,
  output logic                  out_last_of_run
);

  logic [CFG_W-1:0] max_len_r;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= CFG_W'(32);
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  sle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  sle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  sle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_length      (max_len_r),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire
